// ===== hw/rtl/rsl_pkg.sv =====
// Shared types and constants for the recency-sorted id list.
// Used by the list cell and the top level; depends on nothing else.
package rsl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 64;
  localparam int STAMP_W   = 64;
  localparam int CMD_W     = 2;
  localparam int OCC_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // One stored entry of the list.
  typedef struct packed {
    logic        [ID_W-1:0]    id_high;
    logic        [ID_W-1:0]    id_low;
    logic signed [STAMP_W-1:0] stamp;
  } entry_t;

  // What a cell shows to its lower-index neighbor: its own contents.
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   older;
  } up_link_t;

  // What a cell hands to its higher-index neighbor: its entry after the
  // matching entry has been taken out, and the chained match and stop flags.
  typedef struct packed {
    entry_t d_entry;
    logic   d_valid;
    logic   stop;
    logic   m_le;
  } dn_link_t;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_DELETE,
    OP_INSERT
  } op_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   cmp;
    logic   apply;
    op_t    op;
    entry_t key;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_APPLY
  } state_t;

endpackage

// ===== hw/rtl/rsl_cell.sv =====
// One slot of the sorted list: holds an entry, compares it with the key and
// shifts entries with its neighbors. Depends on rsl_pkg.
module rsl_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rsl_pkg::ctl_t     ctl,
  input  rsl_pkg::dn_link_t dn_in,
  output rsl_pkg::dn_link_t dn_out,
  input  rsl_pkg::up_link_t up_in,
  output rsl_pkg::up_link_t up_out
);
  import rsl_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   match_r, older_r;
  logic   m_le, d_valid, d_older, stop;
  entry_t d_entry;

  // Contents of this slot once the matching entry is deleted and the gap closed.
  assign m_le    = dn_in.m_le | match_r;
  assign d_entry = m_le ? up_in.entry : entry_r;
  assign d_valid = m_le ? up_in.valid : valid_r;
  assign d_older = m_le ? up_in.older : older_r;
  // Stop flags form a suffix, so the insert point is the first stop.
  assign stop    = !d_valid || d_older;

  assign dn_out = '{d_entry: d_entry, d_valid: d_valid, stop: stop, m_le: m_le};
  assign up_out = '{entry: entry_r, valid: valid_r, older: older_r};

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (ctl.op)
      OP_DELETE: begin
        entry_nxt = d_entry;
        valid_nxt = d_valid;
      end
      OP_INSERT: begin
        if (dn_in.stop) begin
          entry_nxt = dn_in.d_entry;
          valid_nxt = dn_in.d_valid;
        end else if (stop) begin
          entry_nxt = ctl.key;
          valid_nxt = 1'b1;
        end else begin
          entry_nxt = d_entry;
          valid_nxt = d_valid;
        end
      end
      default: begin
        entry_nxt = entry_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      older_r <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        match_r <= valid_r && (entry_r.id_high == ctl.key.id_high)
                           && (entry_r.id_low == ctl.key.id_low);
        older_r <= valid_r && (entry_r.stamp < ctl.key.stamp);
      end
      if (ctl.apply) begin
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== hw/rtl/recency_sorted_id_list.sv =====
// Top level of the recency-sorted id list: command sequencer and the row of
// list cells. Depends on rsl_pkg and rsl_cell.
//
// Keeps up to DEPTH entries of a 128-bit id and a signed 64-bit timestamp,
// newest first, ids unique. A command is taken at a rising edge where start
// is high and busy is low: update (insert or move an id by its timestamp),
// lookup, or remove. Command code 3 behaves as a lookup.
// After the edge that takes an item, every cell compares its entry with the
// key, then all cells shift or load together; busy is high during the compare
// and the apply. The result appears on the out_ ports for exactly one cycle
// with out_valid high, in the cycle after the update, which is the same cycle
// in which busy is low again, so a new item can be taken at the edge that ends
// it. No new item is taken while busy is high: an item passes the idle state,
// in which it is taken, then the compare and the apply.
// The receiver cannot stall; a result must be taken when out_valid is high.
// Reset (synchronous, active low) empties the list; stored ids and stamps are
// not cleared, only the valid, match and older flags.
module recency_sorted_id_list #(
  parameter int DEPTH = rsl_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic        [rsl_pkg::CMD_W-1:0]  in_command,
  input  logic        [rsl_pkg::ID_W-1:0]   in_id_high,
  input  logic        [rsl_pkg::ID_W-1:0]   in_id_low,
  input  logic signed [rsl_pkg::STAMP_W-1:0] in_stamp,
  output logic                              out_valid,
  output logic                              out_status,
  output logic                              out_found,
  output logic                              out_dropped,
  output logic        [rsl_pkg::OCC_OUT_W-1:0] out_occupancy
);
  import rsl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r;
  entry_t           key_r;
  logic [CW-1:0]    occ_r, occ_nxt;
  logic             valid_r, status_r, found_r, dropped_r;
  logic             status_nxt, dropped_nxt;
  logic             zero_id, found, list_full;
  ctl_t             ctl;
  dn_link_t         dn_link [0:DEPTH];
  up_link_t         up_link [0:DEPTH];
  logic [CW+OCC_OUT_W-1:0] occ_wide;

  assign zero_id   = (key_r.id_high == '0) && (key_r.id_low == '0);
  assign found     = dn_link[DEPTH].m_le;
  assign list_full = up_link[DEPTH-1].valid;

  assign dn_link[0] = '0;
  assign up_link[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    rsl_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .dn_in  (dn_link[k]),
      .dn_out (dn_link[k+1]),
      .up_in  (up_link[k+1]),
      .up_out (up_link[k])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    ctl.cmp     = 1'b0;
    ctl.apply   = 1'b0;
    ctl.op      = OP_KEEP;
    ctl.key     = key_r;
    occ_nxt     = occ_r;
    status_nxt  = 1'b0;
    dropped_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        ctl.cmp   = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = ST_IDLE;
        case (cmd_r)
          CMD_UPDATE: begin
            if (zero_id) begin
              status_nxt = 1'b1;
            end else begin
              ctl.op = OP_INSERT;
              if (!found) begin
                if (list_full) begin
                  dropped_nxt = 1'b1;
                end else begin
                  occ_nxt = occ_r + CW'(1);
                end
              end
            end
          end
          CMD_REMOVE: begin
            ctl.op = OP_DELETE;
            if (found) begin
              occ_nxt = occ_r - CW'(1);
            end
          end
          default: begin
            ctl.op = OP_KEEP;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      occ_r     <= '0;
      valid_r   <= 1'b0;
      status_r  <= 1'b0;
      found_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      valid_r   <= (state_r == ST_APPLY);
      if (state_r == ST_APPLY) begin
        status_r  <= status_nxt;
        found_r   <= found;
        dropped_r <= dropped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      cmd_r         <= in_command;
      key_r.id_high <= in_id_high;
      key_r.id_low  <= in_id_low;
      key_r.stamp   <= in_stamp;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign occ_wide      = (CW + OCC_OUT_W)'(occ_r);
  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_found     = found_r;
  assign out_dropped   = dropped_r;
  assign out_occupancy = occ_wide[OCC_OUT_W-1:0];

endmodule

// ===== tb/sv/tb_recency_sorted_id_list.sv =====
// Self-checking testbench for the recency-sorted id list (recency_sorted_id_list).
// A directed table and a long random run are checked against a queue-based shadow
// of the list. Depends on rsl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_recency_sorted_id_list;
  import rsl_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int NUM_DIRECTED = 18;
  localparam int NUM_RANDOM   = 1330;
  localparam int ID_POOL      = 28;

  // Code 3 has no command of its own; the block treats it as a lookup.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [STAMP_W-1:0] STAMP_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [STAMP_W-1:0] STAMP_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic [ID_W-1:0]           ID_ONES   = '1;

  typedef struct packed {
    logic                 status;
    logic                 found;
    logic                 dropped;
    logic [OCC_OUT_W-1:0] occupancy;
  } reply_t;

  typedef struct {
    logic        [CMD_W-1:0]   cmd;
    logic        [ID_W-1:0]    id_high;
    logic        [ID_W-1:0]    id_low;
    logic signed [STAMP_W-1:0] stamp;
    bit                        has_reply;
    reply_t                    reply;
  } directed_row_t;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic        [CMD_W-1:0]    in_command;
  logic        [ID_W-1:0]     in_id_high;
  logic        [ID_W-1:0]     in_id_low;
  logic signed [STAMP_W-1:0]  in_stamp;
  logic                       out_valid;
  logic                       out_status;
  logic                       out_found;
  logic                       out_dropped;
  logic        [OCC_OUT_W-1:0] out_occupancy;

  entry_t        shadow_entries[$];
  reply_t        pending_replies[$];
  directed_row_t directed_rows[NUM_DIRECTED];
  logic [ID_W-1:0] pool_high[ID_POOL];
  logic [ID_W-1:0] pool_low[ID_POOL];
  int            error_count = 0;
  int            burst_left  = 0;

  recency_sorted_id_list #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_id_high   (in_id_high),
    .in_id_low    (in_id_low),
    .in_stamp     (in_stamp),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_dropped  (out_dropped),
    .out_occupancy(out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    error_count++;
  endtask

  // Applies one command to the shadow list and returns the reply the block must give.
  function automatic reply_t track_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] hi,
                                           logic [ID_W-1:0] lo,
                                           logic signed [STAMP_W-1:0] st);
    reply_t r;
    entry_t fresh;
    int     pos;
    int     ins;
    int     n;
    r   = '0;
    n   = shadow_entries.size();
    pos = 0;
    while (pos < n && !(shadow_entries[pos].id_high == hi && shadow_entries[pos].id_low == lo))
      pos++;
    r.found = (pos < n);
    if (cmd == CMD_UPDATE) begin
      if (hi == '0 && lo == '0) begin
        r.status = 1'b1;
      end else begin
        if (r.found) shadow_entries.delete(pos);
        n   = shadow_entries.size();
        ins = 0;
        // Entries with an equal stamp stay ahead of the new one.
        while (ins < n && $signed(shadow_entries[ins].stamp) >= st)
          ins++;
        if (n >= LIST_DEPTH) r.dropped = 1'b1;
        if (n < LIST_DEPTH || ins < n) begin
          if (n >= LIST_DEPTH) void'(shadow_entries.pop_back());
          fresh.id_high = hi;
          fresh.id_low  = lo;
          fresh.stamp   = st;
          shadow_entries.insert(ins, fresh);
        end
      end
    end else if (cmd == CMD_REMOVE && r.found) begin
      shadow_entries.delete(pos);
    end
    r.occupancy = OCC_OUT_W'(shadow_entries.size());
    return r;
  endfunction

  // Presents one item and returns at the edge where it is taken.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] hi, logic [ID_W-1:0] lo,
                       logic signed [STAMP_W-1:0] st, bit has_reply, reply_t fixed_reply);
    reply_t r;
    start      <= 1'b1;
    in_command <= cmd;
    in_id_high <= hi;
    in_id_low  <= lo;
    in_stamp   <= st;
    do @(posedge clk); while (busy);
    r = track_command(cmd, hi, lo, st);
    pending_replies.insert(pending_replies.size(), has_reply ? fixed_reply : r);
  endtask

  // Bursts of back-to-back items separated by short idle gaps.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic pick_id(output logic [ID_W-1:0] hi, output logic [ID_W-1:0] lo);
    int roll;
    int sel;
    int b;
    roll = $urandom_range(0, 99);
    sel  = $urandom_range(0, ID_POOL - 1);
    hi   = pool_high[sel];
    lo   = pool_low[sel];
    if (roll < 35 && shadow_entries.size() > 0) begin
      sel = $urandom_range(0, shadow_entries.size() - 1);
      hi  = shadow_entries[sel].id_high;
      lo  = shadow_entries[sel].id_low;
    end else if (roll >= 75 && roll < 85) begin
      // A near miss of a known id checks that every id bit takes part in the match.
      b = $urandom_range(0, 127);
      if (b < 64) lo[b] = ~lo[b];
      else hi[b - 64] = ~hi[b - 64];
    end else if (roll >= 85 && roll < 95) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end else if (roll >= 95) begin
      hi = '0;
      lo = '0;
    end
  endtask

  function automatic logic signed [STAMP_W-1:0] pick_stamp();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 64'(longint'($urandom_range(0, 30)) - 15);
    if (roll < 60) begin
      if (shadow_entries.size() == 0) return '0;
      return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].stamp;
    end
    if (roll < 75) begin
      case ($urandom_range(0, 3))
        0: return STAMP_MIN;
        1: return STAMP_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("out_valid with no item outstanding", 0, 1);
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) report_mismatch("status", want.status, out_status);
        if (out_found !== want.found) report_mismatch("found", want.found, out_found);
        if (out_dropped !== want.dropped)
          report_mismatch("dropped", want.dropped, out_dropped);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", want.occupancy, out_occupancy);
      end
    end
  end

  initial begin : stimulus
    logic        [CMD_W-1:0]   cmd;
    logic        [ID_W-1:0]    hi;
    logic        [ID_W-1:0]    lo;
    logic signed [STAMP_W-1:0] st;
    segment_t                  mode;
    int                        seg_left;
    int                        upd_pct;
    int                        rem_pct;
    int                        roll;
    int                        k;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_LOOKUP;
    in_id_high = '0;
    in_id_low  = '0;
    in_stamp   = '0;
    mode       = SEG_MIXED;
    seg_left   = 0;

    // Ids that differ only in which half is zero are kept in the pool on purpose.
    for (k = 0; k < ID_POOL; k++) begin
      pool_high[k] = {$urandom, $urandom};
      pool_low[k]  = {$urandom, $urandom};
    end
    pool_high[0] = ID_ONES;
    pool_low[0]  = ID_ONES;
    pool_high[1] = '0;
    pool_low[1]  = 64'd1;
    pool_high[2] = 64'd1;
    pool_low[2]  = '0;
    pool_high[3] = '0;
    pool_high[4] = {$urandom, $urandom};
    pool_low[4]  = '0;

    directed_rows = '{
      '{CMD_LOOKUP, '0, '0, '0, 1'b1, {1'b0, 1'b0, 1'b0, 5'd0}},
      '{CMD_UPDATE, '0, '0, 64'sd5, 1'b1, {1'b1, 1'b0, 1'b0, 5'd0}},
      '{CMD_REMOVE, '0, '0, '0, 1'b1, {1'b0, 1'b0, 1'b0, 5'd0}},
      '{CMD_UNUSED, ID_ONES, ID_ONES, '0, 1'b1, {1'b0, 1'b0, 1'b0, 5'd0}},
      '{CMD_UPDATE, ID_ONES, ID_ONES, STAMP_MAX, 1'b1, {1'b0, 1'b0, 1'b0, 5'd1}},
      '{CMD_UPDATE, '0, 64'd1, STAMP_MIN, 1'b1, {1'b0, 1'b0, 1'b0, 5'd2}},
      '{CMD_UPDATE, 64'd1, '0, '0, 1'b1, {1'b0, 1'b0, 1'b0, 5'd3}},
      '{CMD_UPDATE, '0, 64'd1, '0, 1'b0, '0},
      '{CMD_UPDATE, ID_ONES, ID_ONES, '1, 1'b1, {1'b0, 1'b1, 1'b0, 5'd3}},
      '{CMD_LOOKUP, 64'd1, '0, STAMP_MAX, 1'b1, {1'b0, 1'b1, 1'b0, 5'd3}},
      '{CMD_UNUSED, 64'd1, '0, '0, 1'b1, {1'b0, 1'b1, 1'b0, 5'd3}},
      '{CMD_UPDATE, '0, '0, STAMP_MAX, 1'b1, {1'b1, 1'b0, 1'b0, 5'd3}},
      '{CMD_REMOVE, 64'd1, '0, '0, 1'b1, {1'b0, 1'b1, 1'b0, 5'd2}},
      '{CMD_REMOVE, 64'd1, '0, '0, 1'b1, {1'b0, 1'b0, 1'b0, 5'd2}},
      '{CMD_UPDATE, ID_ONES, '0, STAMP_MIN, 1'b0, '0},
      '{CMD_LOOKUP, ID_ONES, ID_ONES - 64'd1, STAMP_MIN, 1'b0, '0},
      '{CMD_UPDATE, '0, 64'h8000_0000_0000_0000, 64'sd1, 1'b0, '0},
      '{CMD_REMOVE, ID_ONES, ID_ONES, '1, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      issue(directed_rows[k].cmd, directed_rows[k].id_high, directed_rows[k].id_low,
            directed_rows[k].stamp, directed_rows[k].has_reply, directed_rows[k].reply);
      pace();
    end

    // Segments lean toward filling or draining so the list spends time both full and empty.
    for (k = 0; k < NUM_RANDOM; k++) begin
      if (seg_left == 0) begin
        mode     = segment_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 120);
      end
      seg_left--;
      case (mode)
        SEG_FILL: begin
          upd_pct = 80;
          rem_pct = 8;
        end
        SEG_DRAIN: begin
          upd_pct = 25;
          rem_pct = 55;
        end
        default: begin
          upd_pct = 55;
          rem_pct = 20;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < upd_pct) cmd = CMD_UPDATE;
      else if (roll < upd_pct + rem_pct) cmd = CMD_REMOVE;
      else if (roll < 96) cmd = CMD_LOOKUP;
      else cmd = CMD_UNUSED;
      pick_id(hi, lo);
      st = pick_stamp();
      issue(cmd, hi, lo, st, 1'b0, '0);
      pace();
    end

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
